// ===== design/oktv_pkg.sv =====
`timescale 1ns / 1ps

package oktv_pkg;

  localparam int DEPTH   = 64;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMD_W   = 2;
  localparam int STS_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2
  } status_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             search;
    logic [KEY_W-1:0] search_key;
    logic             exec;
    cmd_e             cmd;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] pos;
    logic [CNT_W-1:0] count;
    logic             any_match;
  } ctrl_t;

  // per-cell contribution to the result, zero unless selected
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] slot;
  } cell_rsp_t;

endpackage

// ===== design/oktv_cell.sv =====
`timescale 1ns / 1ps

module oktv_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [oktv_pkg::IDX_W-1:0] idx_i,
  input  oktv_pkg::ctrl_t         ctrl_i,
  input  logic [oktv_pkg::KEY_W-1:0] nbr_key_i,
  input  logic [oktv_pkg::VAL_W-1:0] nbr_value_i,
  input  logic                    seen_i,
  output logic                    seen_o,
  output logic [oktv_pkg::KEY_W-1:0] key_o,
  output logic [oktv_pkg::VAL_W-1:0] value_o,
  output oktv_pkg::cell_rsp_t     rsp_o
);
  import oktv_pkg::*;

  logic [KEY_W-1:0] key_q, key_d;
  logic [VAL_W-1:0] value_q, value_d;
  logic             match_q, match_d;
  logic             occupied;
  logic             is_tail;
  logic             first;
  logic             rd_sel;
  logic             val_sel;

  assign occupied = {1'b0, idx_i} < ctrl_i.count;
  assign is_tail  = {1'b0, idx_i} == ctrl_i.count;

  // first match wins: a match is first if no lower cell matched
  assign first  = match_q & ~seen_i;
  assign seen_o = seen_i | match_q;

  assign rd_sel  = (ctrl_i.cmd == CMD_READ) && (idx_i == ctrl_i.pos) && occupied;
  assign val_sel = rd_sel || ((ctrl_i.cmd == CMD_GET) && first);

  always_comb begin
    match_d = match_q;
    if (ctrl_i.search) begin
      match_d = occupied && (key_q == ctrl_i.search_key);
    end
  end

  always_comb begin
    key_d   = key_q;
    value_d = value_q;
    if (ctrl_i.exec) begin
      case (ctrl_i.cmd)
        CMD_PUT: begin
          if (first) begin
            value_d = ctrl_i.value;
          end else if (!ctrl_i.any_match && is_tail) begin
            key_d   = ctrl_i.search_key;
            value_d = ctrl_i.value;
          end
        end
        CMD_REMOVE: begin
          // cells from the removed one upwards take their upper neighbour
          if (seen_o) begin
            key_d   = nbr_key_i;
            value_d = nbr_value_i;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign key_o   = key_q;
  assign value_o = value_q;

  assign rsp_o.key   = rd_sel ? key_q : '0;
  assign rsp_o.value = val_sel ? value_q : '0;
  // read at index reports its position only, never a key match
  assign rsp_o.slot  = ((first && (ctrl_i.cmd != CMD_READ)) || rd_sel) ? idx_i : '0;

endmodule

// ===== design/ordered_key_value_table_unit.sv =====
`timescale 1ns / 1ps
// search at acceptance, execute in S_EXEC once the output register is empty or being read;
// a new item is taken only back in S_IDLE; the search compares all 64 cells at
//   once, the execute cycle resolves the first match along the cell chain
// an item is accepted while a previous result still waits in the output register
// reset: asynchronous, active low; clears the entry count and control, the
//   table contents stay undefined until written

module ordered_key_value_table_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [oktv_pkg::CMD_W-1:0]    cmd_i,
  input  logic [oktv_pkg::KEY_W-1:0]    key_i,
  input  logic [oktv_pkg::VAL_W-1:0]    value_i,
  input  logic [oktv_pkg::IDX_W-1:0]    position_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [oktv_pkg::STS_W-1:0]    status_o,
  output logic [oktv_pkg::IDX_W-1:0]    slot_o,
  output logic [oktv_pkg::KEY_W-1:0]    key_out_o,
  output logic [oktv_pkg::VAL_W-1:0]    value_out_o,
  output logic [oktv_pkg::CNT_W-1:0]    count_o
);
  import oktv_pkg::*;

  // one-hot controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  // held item
  cmd_e             cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;
  logic [IDX_W-1:0] pos_q;

  logic [CNT_W-1:0] count_q, count_d;

  // output register
  logic             out_valid_q, out_valid_d;
  status_e          status_q, status_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic [KEY_W-1:0] kout_q, kout_d;
  logic [VAL_W-1:0] vout_q, vout_d;
  logic [CNT_W-1:0] cnt_out_q, cnt_out_d;

  logic             in_fire;
  logic             exec_fire;
  logic             any_match;
  logic             full;
  ctrl_t            ctrl;
  cell_rsp_t        rsp_all;

  // cell chain wiring
  logic [KEY_W-1:0] cell_key   [DEPTH];
  logic [VAL_W-1:0] cell_value [DEPTH];
  logic             seen       [DEPTH+1];
  cell_rsp_t        cell_rsp   [DEPTH];

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign exec_fire  = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  assign any_match = seen[DEPTH];
  assign full      = count_q >= CNT_W'(DEPTH);

  // search runs on the incoming key, execute on the held item
  always_comb begin
    ctrl.search     = in_fire;
    ctrl.search_key = in_fire ? key_i : key_q;
    ctrl.exec       = exec_fire;
    ctrl.cmd        = cmd_q;
    ctrl.value      = value_q;
    ctrl.pos        = pos_q;
    ctrl.count      = count_q;
    ctrl.any_match  = any_match;
  end

  assign seen[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_W-1:0] nbr_key;
    logic [VAL_W-1:0] nbr_value;

    // top cell has no upper neighbour; it only shifts past the count
    if (g == DEPTH - 1) begin : g_last
      assign nbr_key   = cell_key[g];
      assign nbr_value = cell_value[g];
    end else begin : g_mid
      assign nbr_key   = cell_key[g+1];
      assign nbr_value = cell_value[g+1];
    end

    oktv_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (IDX_W'(g)),
      .ctrl_i      (ctrl),
      .nbr_key_i   (nbr_key),
      .nbr_value_i (nbr_value),
      .seen_i      (seen[g]),
      .seen_o      (seen[g+1]),
      .key_o       (cell_key[g]),
      .value_o     (cell_value[g]),
      .rsp_o       (cell_rsp[g])
    );
  end

  // at most one cell is selected, so an or of all gives the selected one
  always_comb begin
    rsp_all = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rsp_all = rsp_all | cell_rsp[i];
    end
  end

  always_comb begin
    status_d  = status_q;
    slot_d    = slot_q;
    kout_d    = kout_q;
    vout_d    = vout_q;
    cnt_out_d = cnt_out_q;
    count_d   = count_q;
    if (exec_fire) begin
      status_d = STS_OK;
      slot_d   = rsp_all.slot;
      kout_d   = rsp_all.key;
      vout_d   = rsp_all.value;
      case (cmd_q)
        CMD_PUT: begin
          if (!any_match) begin
            if (full) begin
              status_d = STS_FULL;
              slot_d   = '0;
            end else begin
              // append at the tail
              slot_d  = count_q[IDX_W-1:0];
              count_d = count_q + CNT_W'(1);
            end
          end
        end
        CMD_REMOVE: begin
          if (any_match) begin
            count_d = count_q - CNT_W'(1);
          end else begin
            status_d = STS_NOT_FOUND;
          end
        end
        CMD_GET: begin
          if (!any_match) begin
            status_d = STS_NOT_FOUND;
          end
        end
        CMD_READ: begin
          if ({1'b0, pos_q} >= count_q) begin
            status_d = STS_NOT_FOUND;
          end
        end
        default: begin
        end
      endcase
      cnt_out_d = count_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (exec_fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item and result payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= cmd_e'(cmd_i);
      key_q   <= key_i;
      value_q <= value_i;
      pos_q   <= position_i;
    end
    status_q  <= status_d;
    slot_q    <= slot_d;
    kout_q    <= kout_d;
    vout_q    <= vout_d;
    cnt_out_q <= cnt_out_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign key_out_o   = kout_q;
  assign value_out_o = vout_q;
  assign count_o     = cnt_out_q;

endmodule
